FILE: src/sblf_pkg.sv
`timescale 1ns / 1ps

package sblf_pkg;

  // Byte that opens a frame while the parser is idle
  localparam logic [7:0] StartByte = 8'hF7;

  // Frame phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DEST   = 3'd1,
    PH_SRC    = 3'd2,
    PH_TYPE   = 3'd3,
    PH_LENGTH = 3'd4,
    PH_DATA   = 3'd5,
    PH_CHECK  = 3'd6
  } phase_t;

  // One parsed result word
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_done;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
    logic [7:0]  frame_type;
    logic [7:0]  frame_length;
    logic [7:0]  check_byte;
  } result_t;

endpackage

FILE: src/start_byte_length_frame_parser.sv
`timescale 1ns / 1ps
// A byte passes the input register, then the result register, before its word
// appears on out_tvalid and out_tdata.
// Throughput: one byte per cycle while the skid slot is free; the result stage holds
// a spare slot so in_tready stays high while one finished word waits downstream.
// Reset (rst_n low, synchronous) returns the parser to idle and clears its field registers.

module start_byte_length_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] payload_byte, [15:8] payload_index,
                                  // [31:16] dest_addr, [47:32] src_addr,
                                  // [55:48] frame_type, [63:56] frame_length,
                                  // [71:64] check_byte
  output logic        out_tuser,  // [0] payload_valid
  output logic        out_tlast   // frame_done
);

  logic              in_v_r;
  logic [7:0]        in_byte_r;
  logic              step;
  logic              stage_ready;
  sblf_pkg::result_t parsed;
  sblf_pkg::result_t res;

  assign step      = in_v_r && stage_ready;
  assign in_tready = !in_v_r || stage_ready;

  // Input register: hold the byte until the result stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_byte_r <= in_tdata;
  end

  sblf_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .result  (parsed)
  );

  sblf_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_v_r),
    .up_ready (stage_ready),
    .up_data  (parsed),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res)
  );

  // Pack the result word
  assign out_tdata = {res.check_byte, res.frame_length, res.frame_type, res.src_addr,
                      res.dest_addr, res.payload_index, res.payload_byte};
  assign out_tuser = res.payload_valid;
  assign out_tlast = res.frame_done;

endmodule

FILE: src/sblf_parse.sv
`timescale 1ns / 1ps

module sblf_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output sblf_pkg::result_t result
);

  sblf_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [15:0] dest_r, dest_nxt;
  logic [15:0] src_r, src_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  count_inc;

  assign count_inc = byte_count_r + 8'd1;

  // Next state of the frame phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      sblf_pkg::PH_DEST: begin
        if (count_inc >= 8'd2) phase_nxt = sblf_pkg::PH_SRC;
      end
      sblf_pkg::PH_SRC: begin
        if (count_inc >= 8'd2) phase_nxt = sblf_pkg::PH_TYPE;
      end
      sblf_pkg::PH_TYPE: begin
        phase_nxt = sblf_pkg::PH_LENGTH;
      end
      sblf_pkg::PH_LENGTH: begin
        phase_nxt = (rx_byte == 8'd0) ? sblf_pkg::PH_CHECK : sblf_pkg::PH_DATA;
      end
      sblf_pkg::PH_DATA: begin
        if (count_inc >= length_r) phase_nxt = sblf_pkg::PH_CHECK;
      end
      sblf_pkg::PH_CHECK: begin
        phase_nxt = sblf_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = (rx_byte == sblf_pkg::StartByte) ? sblf_pkg::PH_DEST
                                                      : sblf_pkg::PH_IDLE;
      end
    endcase
  end

  // Field registers, counter and result word
  always_comb begin
    byte_count_nxt = byte_count_r;
    dest_nxt       = dest_r;
    src_nxt        = src_r;
    type_nxt       = type_r;
    length_nxt     = length_r;
    result         = '0;
    unique case (phase_r)
      sblf_pkg::PH_DEST: begin
        dest_nxt       = {dest_r[7:0], rx_byte};
        byte_count_nxt = (count_inc >= 8'd2) ? 8'd0 : count_inc;
      end
      sblf_pkg::PH_SRC: begin
        src_nxt        = {src_r[7:0], rx_byte};
        byte_count_nxt = (count_inc >= 8'd2) ? 8'd0 : count_inc;
      end
      sblf_pkg::PH_TYPE: begin
        type_nxt = rx_byte;
      end
      sblf_pkg::PH_LENGTH: begin
        length_nxt     = rx_byte;
        byte_count_nxt = 8'd0;
      end
      sblf_pkg::PH_DATA: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
        result.payload_index = byte_count_r;
        byte_count_nxt       = (count_inc >= length_r) ? 8'd0 : count_inc;
      end
      sblf_pkg::PH_CHECK: begin
        result.frame_done = 1'b1;
        result.check_byte = rx_byte;
      end
      default: begin
        if (rx_byte == sblf_pkg::StartByte) byte_count_nxt = 8'd0;
      end
    endcase
    result.dest_addr    = dest_nxt;
    result.src_addr     = src_nxt;
    result.frame_type   = type_nxt;
    result.frame_length = length_nxt;
  end

  // Advance state once per word passed downstream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sblf_pkg::PH_IDLE;
      byte_count_r <= 8'd0;
      dest_r       <= 16'd0;
      src_r        <= 16'd0;
      type_r       <= 8'd0;
      length_r     <= 8'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      dest_r       <= dest_nxt;
      src_r        <= src_nxt;
      type_r       <= type_nxt;
      length_r     <= length_nxt;
    end
  end

endmodule

FILE: src/sblf_out_reg.sv
`timescale 1ns / 1ps

module sblf_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  sblf_pkg::result_t  up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output sblf_pkg::result_t  dn_data
);

  logic              main_v_r;
  logic              skid_v_r;
  sblf_pkg::result_t main_r;
  sblf_pkg::result_t skid_r;
  logic              up_fire;
  logic              dn_fire;

  assign up_ready = !skid_v_r;
  assign up_fire  = up_valid && !skid_v_r;
  assign dn_fire  = main_v_r && dn_ready;
  assign dn_valid = main_v_r;
  assign dn_data  = main_r;

  // Valid flags of the main and skid slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (up_fire) begin
        main_v_r <= 1'b1;
        if (main_v_r && !dn_ready) skid_v_r <= 1'b1;
      end else if (dn_fire) begin
        if (skid_v_r) skid_v_r <= 1'b0;
        else main_v_r <= 1'b0;
      end
    end
  end

  // Payload: load main directly, park in skid when stalled
  always_ff @(posedge clk) begin
    if (up_fire) begin
      if (!main_v_r || dn_ready) main_r <= up_data;
      else skid_r <= up_data;
    end else if (dn_fire && skid_v_r) begin
      main_r <= skid_r;
    end
  end

endmodule

FILE: src/sblf_checker.sv
`timescale 1ns / 1ps

module sblf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A word is either a payload byte or a frame end, never both
  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser && out_tlast))
    else $error("payload and frame end flagged together");

  // Payload index stays below the frame length
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[15:8] < out_tdata[63:56]))
    else $error("payload index beyond frame length");

  // Non-payload words carry zero payload fields
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[15:0] == 16'd0))
    else $error("payload fields set on a non-payload word");

  // Check byte is zero unless the word ends a frame
  a_check_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[71:64] == 8'd0))
    else $error("check byte set outside frame end");

  // Stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output word changed while stalled");

endmodule

bind start_byte_length_frame_parser sblf_checker u_sblf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
